>>> hw/rtl/pbr_pkg.sv
// Shared types and constants of the polynomial bisection root unit.
`timescale 1ns / 1ps

package pbr_pkg;

   localparam int FIELD_W     = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int DEGREE_W    = 3;
   localparam int TOL_W       = 25;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_0    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLY_DEG  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = 3'd6;

   localparam logic [DEGREE_W-1:0] DEGREE_RESET = 3'd4;
   localparam logic [TOL_W-1:0]    TOL_RESET    = 25'd1;

   localparam int MUL_STEP_W = 3;
   localparam logic [MUL_STEP_W-1:0] MUL_LAST_STEP = 3'd4;

   typedef enum logic [1:0] {
      SHIFT_NONE = 2'd0,
      SHIFT_HALF = 2'd1,
      SHIFT_FULL = 2'd2
   } pp_shift_type;

   typedef enum logic [9:0] {
      S_IDLE       = 10'b00_0000_0001,
      S_BOUND_GO   = 10'b00_0000_0010,
      S_BOUND_WAIT = 10'b00_0000_0100,
      S_CHECK      = 10'b00_0000_1000,
      S_MUL_GO     = 10'b00_0001_0000,
      S_MUL_WAIT   = 10'b00_0010_0000,
      S_ROUND      = 10'b00_0100_0000,
      S_ADD        = 10'b00_1000_0000,
      S_SIGN       = 10'b01_0000_0000,
      S_DONE       = 10'b10_0000_0000
   } state_type;

endpackage

>>> hw/rtl/pbr_mul.sv
// Shared unsigned multiplier: four half-width partial products accumulated over cycles.
`timescale 1ns / 1ps

module pbr_mul
   import pbr_pkg::*;
#(
   parameter int HALF_W = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mul_start,
   input  logic [2*HALF_W-1:0]   mul_op_a,
   input  logic [2*HALF_W-1:0]   mul_op_b,
   output logic                  mul_done,
   output logic [4*HALF_W-1:0]   mul_product
);

   localparam int OP_W   = 2 * HALF_W;
   localparam int PROD_W = 4 * HALF_W;

   logic [OP_W-1:0]       op_a_ff, op_b_ff;
   logic [MUL_STEP_W-1:0] step_ff, step_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [OP_W-1:0]       pp_ff, pp_in;
   pp_shift_type          shift_ff, shift_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;

   logic [HALF_W-1:0] a_chunk, b_chunk;
   logic [PROD_W-1:0] pp_aligned;

   assign a_chunk = step_ff[0] ? op_a_ff[OP_W-1:HALF_W] : op_a_ff[HALF_W-1:0];
   assign b_chunk = step_ff[1] ? op_b_ff[OP_W-1:HALF_W] : op_b_ff[HALF_W-1:0];

   always_comb begin
      case (shift_ff)
         SHIFT_NONE: pp_aligned = PROD_W'(pp_ff);
         SHIFT_HALF: pp_aligned = PROD_W'(pp_ff) << HALF_W;
         SHIFT_FULL: pp_aligned = PROD_W'(pp_ff) << OP_W;
         default:    pp_aligned = '0;
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      pp_in    = pp_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      if (mul_start) begin
         step_in = '0;
         run_in  = 1'b1;
         acc_in  = '0;
      end else if (run_ff) begin
         if (step_ff != '0) begin
            acc_in = acc_ff + pp_aligned;
         end
         if (step_ff == MUL_LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            pp_in    = OP_W'(a_chunk) * OP_W'(b_chunk);
            shift_in = pp_shift_type'({1'b0, step_ff[0]} + {1'b0, step_ff[1]});
            step_in  = step_ff + MUL_STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         op_a_ff <= mul_op_a;
         op_b_ff <= mul_op_b;
      end
      pp_ff    <= pp_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign mul_done    = done_ff;
   assign mul_product = acc_ff;

endmodule

>>> hw/rtl/polynomial_bisection_root_unit.sv
// Top level of the polynomial bisection root unit: sequencer, Horner datapath and CSRs.
`timescale 1ns / 1ps

// Finds a root of c0 + c1*x + ... + c4*x^4 (signed fixed point, FRAC_BITS fraction
// bits) by bisecting the bracket given with each request transaction; one response
// transaction per request. The unit works on one request at a time and holds
// req_stall high meanwhile. All multiplies go through one shared multiplier that
// needs four partial-product passes per multiply. The number of halvings is at most
// MAX_ITER. The response sits in an output register, so the next request is taken
// while the previous response is still waiting. The user must write CSRs only while
// the unit is idle; the unit itself does not enforce this.

module polynomial_bisection_root_unit
   import pbr_pkg::*;
#(
   parameter int WORD_WIDTH = 48,
   parameter int FRAC_BITS  = 24,
   parameter int MAX_DEGREE = 4,
   parameter int MAX_ITER   = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [FIELD_W-1:0]        csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [FIELD_W-1:0] req_interval_low,
   input  logic signed [FIELD_W-1:0] req_interval_high,
   input  logic signed [FIELD_W-1:0] req_value_at_low,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [FIELD_W-1:0] rsp_root,
   output logic                      rsp_exact_zero,
   output logic                      rsp_iteration_cap_hit,
   output logic                      rsp_overflow_seen
);

   localparam int W       = WORD_WIDTH;
   localparam int F       = FRAC_BITS;
   localparam int XW      = (W > FIELD_W) ? W : FIELD_W;
   localparam int HALF_A  = (W + 1) / 2;
   localparam int HALF_B  = (TOL_W + 1) / 2;
   localparam int HALF_W  = (HALF_A > HALF_B) ? HALF_A : HALF_B;
   localparam int OP_W    = 2 * HALF_W;
   localparam int PROD_W  = 4 * HALF_W;
   localparam int CMP_W   = PROD_W + F;
   localparam int DW      = $clog2(MAX_DEGREE + 1);
   localparam int IW      = $clog2(MAX_ITER + 1);

   localparam logic [W-1:0]        WMAX_U   = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMAX     = WMAX_U;
   localparam logic signed [W-1:0] WMIN     = ~WMAX_U;
   localparam logic [W-1:0]        ONE_Q    = W'(1) << F;
   localparam logic [PROD_W:0]     HALF_LSB = (PROD_W+1)'(1) << (F - 1);
   localparam logic [PROD_W:0]     LIM_POS  = (PROD_W+1)'(WMAX_U);
   localparam logic [PROD_W:0]     LIM_NEG  = (PROD_W+1)'(WMAX_U) + (PROD_W+1)'(1);

   function automatic logic signed [W-1:0] to_word(input logic signed [FIELD_W-1:0] v);
      logic signed [XW-1:0] x, lim_hi, lim_lo;
      x      = XW'(v);
      lim_hi = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
      lim_lo = ~lim_hi;
      if (x > lim_hi) x = lim_hi;
      else if (x < lim_lo) x = lim_lo;
      return x[W-1:0];
   endfunction

   function automatic logic signed [FIELD_W-1:0] to_field(input logic signed [W-1:0] v);
      logic signed [XW-1:0] x, lim_hi, lim_lo;
      x      = XW'(v);
      lim_hi = {{(XW-FIELD_W+1){1'b0}}, {(FIELD_W-1){1'b1}}};
      lim_lo = ~lim_hi;
      if (x > lim_hi) x = lim_hi;
      else if (x < lim_lo) x = lim_lo;
      return x[FIELD_W-1:0];
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      return v[W-1] ? W'(-v) : W'(v);
   endfunction

   // configuration
   logic signed [W-1:0] coef_ff [MAX_DEGREE+1];
   logic [DEGREE_W-1:0] degree_ff;
   logic [TOL_W-1:0]    tol_ff;

   // sequencer and datapath
   state_type           state_ff, state_in;
   logic signed [W-1:0] a_ff, a_in, b_ff, b_in, xm_ff, xm_in, p_ff, p_in, root_ff, root_in;
   logic                pa_nz_ff, pa_nz_in, pa_neg_ff, pa_neg_in, neg_ff, neg_in;
   logic                zero_ff, zero_in, cap_ff, cap_in, sat_ff, sat_in;
   logic [DW-1:0]       k_ff, k_in;
   logic [IW-1:0]       it_ff, it_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [FIELD_W-1:0] rsp_root_ff;
   logic                      rsp_zero_ff, rsp_cap_ff, rsp_ovf_ff, rsp_load;

   logic                      mul_start, mul_done;
   logic [OP_W-1:0]           mul_op_a, mul_op_b;
   logic [PROD_W-1:0]         mul_product;

   logic signed [W:0]   sum_ab, diff_ab, sum_pc;
   logic signed [W-1:0] mid_w, coef_rd, req_pa_w;
   logic [W-1:0]        width_w, bound_m;
   logic [DW-1:0]       deg_eff, coef_idx;
   logic                tol_pass, req_take;
   logic [PROD_W:0]     rnd, rnd_q;

   assign sum_ab  = (W+1)'(a_ff) + (W+1)'(b_ff);
   assign mid_w   = sum_ab[W:1];
   assign diff_ab = (W+1)'(b_ff) - (W+1)'(a_ff);
   assign width_w = diff_ab[W] ? W'(-diff_ab) : diff_ab[W-1:0];
   assign bound_m = mag(a_ff) + ONE_Q;
   assign tol_pass = (CMP_W'(width_w) << F) <= CMP_W'(mul_product);

   assign deg_eff  = (degree_ff > DEGREE_W'(MAX_DEGREE)) ? DW'(MAX_DEGREE)
                                                          : degree_ff[DW-1:0];
   assign coef_idx = (state_ff == S_CHECK) ? deg_eff : k_ff - DW'(1);
   assign coef_rd  = coef_ff[coef_idx];
   assign sum_pc   = (W+1)'(p_ff) + (W+1)'(coef_rd);

   assign rnd   = (PROD_W+1)'(mul_product) + HALF_LSB;
   assign rnd_q = rnd >> F;

   assign mul_start = (state_ff == S_BOUND_GO) || (state_ff == S_MUL_GO);
   assign mul_op_a  = (state_ff == S_BOUND_GO) ? OP_W'(bound_m) : OP_W'(mag(p_ff));
   assign mul_op_b  = (state_ff == S_BOUND_GO) ? OP_W'(tol_ff) : OP_W'(mag(xm_ff));

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign req_pa_w  = to_word(req_value_at_low);

   pbr_mul #(
      .HALF_W (HALF_W)
   ) u_mul (
      .clock       (clock),
      .reset       (reset),
      .mul_start   (mul_start),
      .mul_op_a    (mul_op_a),
      .mul_op_b    (mul_op_b),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      xm_in     = xm_ff;
      p_in      = p_ff;
      root_in   = root_ff;
      pa_nz_in  = pa_nz_ff;
      pa_neg_in = pa_neg_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      cap_in    = cap_ff;
      sat_in    = sat_ff;
      k_in      = k_ff;
      it_in     = it_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a_in      = to_word(req_interval_low);
               b_in      = to_word(req_interval_high);
               pa_nz_in  = |req_pa_w;
               pa_neg_in = req_pa_w[W-1];
               zero_in   = 1'b0;
               cap_in    = 1'b0;
               sat_in    = 1'b0;
               it_in     = '0;
               state_in  = S_BOUND_GO;
            end
         end
         S_BOUND_GO: state_in = S_BOUND_WAIT;
         S_BOUND_WAIT: begin
            if (mul_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (tol_pass) begin
               root_in  = mid_w;
               state_in = S_DONE;
            end else if (it_ff >= IW'(MAX_ITER)) begin
               cap_in   = 1'b1;
               root_in  = mid_w;
               state_in = S_DONE;
            end else begin
               xm_in    = mid_w;
               p_in     = coef_rd;
               k_in     = deg_eff;
               state_in = (deg_eff == '0) ? S_SIGN : S_MUL_GO;
            end
         end
         S_MUL_GO: begin
            neg_in   = p_ff[W-1] ^ xm_ff[W-1];
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) state_in = S_ROUND;
         end
         S_ROUND: begin
            if (!neg_ff) begin
               if (rnd_q > LIM_POS) begin
                  p_in   = WMAX;
                  sat_in = 1'b1;
               end else begin
                  p_in = rnd_q[W-1:0];
               end
            end else begin
               if (rnd_q > LIM_NEG) begin
                  p_in   = WMIN;
                  sat_in = 1'b1;
               end else begin
                  p_in = W'(-rnd_q[W-1:0]);
               end
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            if (sum_pc > (W+1)'(WMAX)) begin
               p_in   = WMAX;
               sat_in = 1'b1;
            end else if (sum_pc < (W+1)'(WMIN)) begin
               p_in   = WMIN;
               sat_in = 1'b1;
            end else begin
               p_in = sum_pc[W-1:0];
            end
            k_in     = k_ff - DW'(1);
            state_in = (k_ff == DW'(1)) ? S_SIGN : S_MUL_GO;
         end
         S_SIGN: begin
            if (p_ff == '0) begin
               zero_in  = 1'b1;
               root_in  = xm_ff;
               state_in = S_DONE;
            end else begin
               if (pa_nz_ff && (pa_neg_ff != p_ff[W-1])) begin
                  b_in = xm_ff;
               end else begin
                  a_in      = xm_ff;
                  pa_nz_in  = 1'b1;
                  pa_neg_in = p_ff[W-1];
               end
               it_in    = it_ff + IW'(1);
               state_in = S_BOUND_GO;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_DEGREE; i++) coef_ff[i] <= '0;
         degree_ff <= DEGREE_RESET;
         tol_ff    <= TOL_RESET;
      end else if (csr_write_enable) begin
         for (int i = 0; i <= MAX_DEGREE; i++) begin
            if (csr_index == CSR_COEF_0 + CSR_INDEX_W'(i)) coef_ff[i] <= to_word(csr_write_data);
         end
         if (csr_index == CSR_POLY_DEG) degree_ff <= csr_write_data[DEGREE_W-1:0];
         if (csr_index == CSR_TOLERANCE) tol_ff <= csr_write_data[TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      xm_ff     <= xm_in;
      p_ff      <= p_in;
      root_ff   <= root_in;
      pa_nz_ff  <= pa_nz_in;
      pa_neg_ff <= pa_neg_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      cap_ff    <= cap_in;
      sat_ff    <= sat_in;
      k_ff      <= k_in;
      it_ff     <= it_in;
      if (rsp_load) begin
         rsp_root_ff <= to_field(root_ff);
         rsp_zero_ff <= zero_ff;
         rsp_cap_ff  <= cap_ff;
         rsp_ovf_ff  <= sat_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_root              = rsp_root_ff;
   assign rsp_exact_zero        = rsp_zero_ff;
   assign rsp_iteration_cap_hit = rsp_cap_ff;
   assign rsp_overflow_seen     = rsp_ovf_ff;

   a_take_starts_bound: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_BOUND_GO))
      else $error("accepted transaction did not start a bound multiply");

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_BOUND_WAIT || state_ff == S_MUL_WAIT))
      else $error("multiplier finished while sequencer was not waiting");

   a_add_has_term: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD || state_ff == S_MUL_GO) |-> (k_ff != '0))
      else $error("Horner step with no coefficient left");

   a_iter_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (it_ff <= IW'(MAX_ITER)))
      else $error("halving count beyond limit");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_exact_zero && rsp_iteration_cap_hit))
      else $error("exact zero and iteration cap both set");

endmodule
